// ===== rtl/bmprle8_pkg.sv =====
// Shared types and constants of the BMP RLE8 decoder.
`timescale 1ns / 1ps

package bmprle8_pkg;

  localparam int DEF_MAX_WIDTH   = 4096;
  localparam int DEF_MAX_HEIGHT  = 4096;
  localparam int DEF_QUEUE_DEPTH = 4;
  localparam int PALETTE_ENTRIES = 256;

  localparam logic [1:0] ACT_DATA    = 2'd0;
  localparam logic [1:0] ACT_PALETTE = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BOTTOM = 2'd2;

  typedef enum logic [1:0] {
    CMD_RUN = 2'd0,
    CMD_END = 2'd1,
    CMD_PAL = 2'd2
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [7:0]  index;
    logic [23:0] rgb;
    logic [11:0] row;
    logic [11:0] column;
    logic [7:0]  length;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic [11:0] row;
    logic [11:0] column;
    logic [7:0]  length;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } result_t;

endpackage

// ===== rtl/bmprle8_queue.sv =====
// Small register queue with full, empty and fill count.
`timescale 1ns / 1ps

module bmprle8_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             din,
  output logic                         full,
  input  logic                         pop,
  output logic [WIDTH-1:0]             dout,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == CNT_W'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];
  assign count   = fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("Request pushed into a full queue.");
  a_fill_bounded: assert property (@(posedge clk) disable iff (rst) fill <= CNT_W'(DEPTH))
    else $error("Queue fill count exceeds its depth.");
  a_push_makes_nonempty: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> !empty)
    else $error("Queue is empty after a push.");

endmodule

// ===== rtl/bmprle8_front.sv =====
// Front end: configuration registers, RLE8 stream parser and command generation.
`timescale 1ns / 1ps

module bmprle8_front #(
  parameter int MAX_WIDTH  = bmprle8_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bmprle8_pkg::DEF_MAX_HEIGHT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data,
  input  logic               push,
  input  logic               cmd_full,
  input  logic [1:0]         action,
  input  logic [7:0]         data_byte,
  input  logic [7:0]         palette_index,
  input  logic [7:0]         palette_red,
  input  logic [7:0]         palette_green,
  input  logic [7:0]         palette_blue,
  output logic               cmd_push,
  output bmprle8_pkg::cmd_t  cmd
);
  import bmprle8_pkg::*;

  localparam int WCAP = (MAX_WIDTH > 8191) ? 8191 : MAX_WIDTH;
  localparam int HCAP = (MAX_HEIGHT > 8191) ? 8191 : MAX_HEIGHT;

  typedef enum logic [6:0] {
    PH_FIRST  = 7'b0000001,
    PH_COLOUR = 7'b0000010,
    PH_ESCAPE = 7'b0000100,
    PH_DX     = 7'b0001000,
    PH_DY     = 7'b0010000,
    PH_ABS    = 7'b0100000,
    PH_PAD    = 7'b1000000
  } phase_t;

  logic [12:0] image_width;
  logic [12:0] image_height;
  logic        bottom_up;

  phase_t      phase, phase_next;
  logic [7:0]  held_count, held_count_next;
  logic [7:0]  absolute_left, absolute_left_next;
  logic [7:0]  held_delta_x, held_delta_x_next;
  logic [12:0] cur_column, cur_column_next;
  logic [12:0] cur_row, cur_row_next;
  logic        finished, finished_next;

  logic        accept;
  logic [12:0] w_eff;
  logic [12:0] h_eff;
  logic        col_in_row;
  logic [12:0] room;
  logic [7:0]  run_len;
  logic [12:0] row_clamp;
  logic [12:0] row_flip;
  logic [11:0] col_sat;
  logic [13:0] col_sum;
  logic [13:0] row_sum;
  logic [12:0] col_delta;
  logic [12:0] row_delta;
  logic [12:0] row_inc;
  logic [7:0]  abs_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 13'd1;
      image_height <= 13'd1;
      bottom_up    <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        REG_BOTTOM: bottom_up    <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  assign accept = push && !cmd_full;

  always_comb begin
    w_eff = image_width;
    if (w_eff == '0) w_eff = 13'd1;
    if (w_eff > 13'(WCAP)) w_eff = 13'(WCAP);
    h_eff = image_height;
    if (h_eff == '0) h_eff = 13'd1;
    if (h_eff > 13'(HCAP)) h_eff = 13'(HCAP);

    col_in_row = cur_column < w_eff;
    room       = w_eff - cur_column;
    run_len    = (room < {5'd0, held_count}) ? room[7:0] : held_count;
    if (!col_in_row) run_len = 8'd0;

    row_clamp = (cur_row >= h_eff) ? h_eff - 13'd1 : cur_row;
    row_flip  = bottom_up ? h_eff - 13'd1 - row_clamp : row_clamp;
    col_sat   = (cur_column > 13'd4095) ? 12'd4095 : cur_column[11:0];

    col_sum   = {1'b0, cur_column} + {6'd0, held_delta_x};
    row_sum   = {1'b0, cur_row} + {6'd0, data_byte};
    col_delta = col_sum[13] ? 13'd8191 : col_sum[12:0];
    row_delta = row_sum[13] ? 13'd8191 : row_sum[12:0];
    row_inc   = cur_row + 13'd1;
    abs_dec   = (absolute_left != '0) ? absolute_left - 8'd1 : 8'd0;
  end

  always_comb begin
    phase_next         = phase;
    held_count_next    = held_count;
    absolute_left_next = absolute_left;
    held_delta_x_next  = held_delta_x;
    cur_column_next    = cur_column;
    cur_row_next       = cur_row;
    finished_next      = finished;
    cmd_push           = 1'b0;
    cmd                = '0;
    cmd.op             = CMD_RUN;

    if (accept) begin
      case (action)
        ACT_PALETTE: begin
          cmd_push  = 1'b1;
          cmd.op    = CMD_PAL;
          cmd.index = palette_index;
          cmd.rgb   = {palette_red, palette_green, palette_blue};
        end
        ACT_RESTART: begin
          phase_next         = PH_FIRST;
          held_count_next    = '0;
          absolute_left_next = '0;
          held_delta_x_next  = '0;
          cur_column_next    = '0;
          cur_row_next       = '0;
          finished_next      = 1'b0;
        end
        ACT_DATA: begin
          if (!finished) begin
            case (phase)
              PH_COLOUR: begin
                cmd_push        = 1'b1;
                cmd.row         = row_flip[11:0];
                cmd.column      = col_sat;
                cmd.length      = run_len;
                cmd.index       = data_byte;
                cur_column_next = cur_column + {5'd0, run_len};
                phase_next      = PH_FIRST;
              end
              PH_ESCAPE: begin
                phase_next = PH_FIRST;
                if (data_byte == 8'd0) begin
                  cur_row_next    = row_inc;
                  cur_column_next = '0;
                  if (row_inc >= h_eff) begin
                    cmd_push      = 1'b1;
                    cmd.op        = CMD_END;
                    finished_next = 1'b1;
                  end
                end else if (data_byte == 8'd1) begin
                  cmd_push      = 1'b1;
                  cmd.op        = CMD_END;
                  finished_next = 1'b1;
                end else if (data_byte == 8'd2) begin
                  phase_next = PH_DX;
                end else begin
                  held_count_next    = data_byte;
                  absolute_left_next = data_byte;
                  phase_next         = PH_ABS;
                end
              end
              PH_DX: begin
                held_delta_x_next = data_byte;
                phase_next        = PH_DY;
              end
              PH_DY: begin
                cur_column_next = col_delta;
                cur_row_next    = row_delta;
                phase_next      = PH_FIRST;
                if (row_delta >= h_eff) begin
                  cmd_push      = 1'b1;
                  cmd.op        = CMD_END;
                  finished_next = 1'b1;
                end
              end
              PH_ABS: begin
                if (col_in_row) begin
                  cmd_push        = 1'b1;
                  cmd.row         = row_flip[11:0];
                  cmd.column      = col_sat;
                  cmd.length      = 8'd1;
                  cmd.index       = data_byte;
                  cur_column_next = cur_column + 13'd1;
                end
                absolute_left_next = abs_dec;
                if (abs_dec == '0) begin
                  phase_next = held_count[0] ? PH_PAD : PH_FIRST;
                end
              end
              PH_PAD: begin
                phase_next = PH_FIRST;
              end
              default: begin
                if (data_byte == 8'd0) begin
                  phase_next = PH_ESCAPE;
                end else begin
                  held_count_next = data_byte;
                  phase_next      = PH_COLOUR;
                end
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_FIRST;
      held_count    <= '0;
      absolute_left <= '0;
      held_delta_x  <= '0;
      cur_column    <= '0;
      cur_row       <= '0;
      finished      <= 1'b0;
    end else begin
      phase         <= phase_next;
      held_count    <= held_count_next;
      absolute_left <= absolute_left_next;
      held_delta_x  <= held_delta_x_next;
      cur_column    <= cur_column_next;
      cur_row       <= cur_row_next;
      finished      <= finished_next;
    end
  end

endmodule

// ===== rtl/bmprle8_back.sv =====
// Back end: palette memory, colour lookup and result queue.
`timescale 1ns / 1ps

module bmprle8_back #(
  parameter int QUEUE_DEPTH = bmprle8_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_empty,
  input  bmprle8_pkg::cmd_t     cmd,
  output logic                  cmd_pop,
  input  logic                  pop,
  output logic                  empty,
  output bmprle8_pkg::result_t  result
);
  import bmprle8_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

  logic [23:0]      palette [PALETTE_ENTRIES];
  logic [23:0]      rd_rgb;
  logic             pipe_valid;
  cmd_t             pipe_cmd;
  logic [CNT_W-1:0] out_count;
  logic [CNT_W:0]   in_use;
  result_t          pipe_result;
  logic [$bits(result_t)-1:0] queue_dout;

  assign in_use  = {1'b0, out_count} + {{CNT_W{1'b0}}, pipe_valid};
  assign cmd_pop = !cmd_empty && (in_use < (CNT_W+1)'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.op == CMD_PAL) begin
      palette[cmd.index] <= cmd.rgb;
    end
    if (cmd_pop && cmd.op == CMD_RUN) begin
      rd_rgb <= palette[cmd.index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else begin
      pipe_valid <= cmd_pop && (cmd.op != CMD_PAL);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      pipe_cmd <= cmd;
    end
  end

  always_comb begin
    pipe_result        = '0;
    pipe_result.row    = pipe_cmd.row;
    pipe_result.column = pipe_cmd.column;
    pipe_result.length = pipe_cmd.length;
    case (pipe_cmd.op)
      CMD_END: begin
        pipe_result      = '0;
        pipe_result.kind = 1'b1;
      end
      default: begin
        pipe_result.red   = rd_rgb[23:16];
        pipe_result.green = rd_rgb[15:8];
        pipe_result.blue  = rd_rgb[7:0];
      end
    endcase
  end

  bmprle8_queue #(
    .WIDTH($bits(result_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_result_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (pipe_valid),
    .din   (pipe_result),
    .full  (),
    .pop   (pop),
    .dout  (queue_dout),
    .empty (empty),
    .count (out_count)
  );

  assign result = result_t'(queue_dout);

endmodule

// ===== rtl/bmp_rle8_decoder.sv =====
// Top level of the BMP RLE8 decoder.
`timescale 1ns / 1ps

// The decoder takes one request per clock while full is low: a stream byte, a
// palette write or a restart. Bytes that produce a run or an end-of-image
// request pass through the command queue, the registered palette read and the
// result queue, in that order. The sustained rate is one request per cycle
// while results are popped; it is set by the single palette memory port, which
// the back end uses at most once per command. Full rises only when results are
// not popped and the command queue fills. Palette entries that were never
// written read back undefined colours; there is no clearing pass.

module bmp_rle8_decoder #(
  parameter int MAX_WIDTH   = bmprle8_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = bmprle8_pkg::DEF_MAX_HEIGHT,
  parameter int QUEUE_DEPTH = bmprle8_pkg::DEF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  palette_index,
  input  logic [7:0]  palette_red,
  input  logic [7:0]  palette_green,
  input  logic [7:0]  palette_blue,
  output logic        empty,
  input  logic        pop,
  output logic        kind,
  output logic [11:0] out_row,
  output logic [11:0] start_column,
  output logic [7:0]  run_length,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);
  import bmprle8_pkg::*;

  logic    cmd_push;
  cmd_t    cmd_in;
  logic    cmd_full;
  logic    cmd_pop;
  logic    cmd_empty;
  logic [$bits(cmd_t)-1:0] cmd_dout;
  result_t result;

  bmprle8_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .cmd_full      (cmd_full),
    .action        (action),
    .data_byte     (data_byte),
    .palette_index (palette_index),
    .palette_red   (palette_red),
    .palette_green (palette_green),
    .palette_blue  (palette_blue),
    .cmd_push      (cmd_push),
    .cmd           (cmd_in)
  );

  bmprle8_queue #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_dout),
    .empty (cmd_empty),
    .count ()
  );

  bmprle8_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_t'(cmd_dout)),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

  assign full         = cmd_full;
  assign kind         = result.kind;
  assign out_row      = result.row;
  assign start_column = result.column;
  assign run_length   = result.length;
  assign red          = result.red;
  assign green        = result.green;
  assign blue         = result.blue;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the BMP RLE8 decoder, with a built-in decoder model.
`timescale 1ns / 1ps

module testbench;
  import bmprle8_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [1:0] REG_NONE   = 2'd3;

  localparam logic [7:0] ESC_MARK  = 8'd0;
  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  localparam logic KIND_RUN = 1'b0;
  localparam logic KIND_END = 1'b1;

  localparam int COL_LIMIT     = 8191;
  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 20;
  localparam int HOLD_AT       = 600;
  localparam int LONG_HOLD     = 400;
  localparam int STALL_LIMIT   = 5000;
  localparam int PHASES        = 9;
  localparam int PHASE_ITEMS   = 120;

  typedef enum logic [2:0] {
    PH_FIRST, PH_COLOUR, PH_ESCAPE, PH_DX, PH_DY, PH_ABS, PH_PAD
  } parse_phase_t;

  typedef enum logic [1:0] {
    POP_ALWAYS, POP_COIN, POP_PERIODIC, POP_SPARSE
  } stall_mode_t;

  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  reg_idx;
    logic [12:0] reg_val;
    logic [1:0]  act;
    logic [7:0]  byte_val;
    logic [7:0]  pal_idx;
    logic [23:0] rgb;
  } req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_WIDTH;
  logic [12:0] cfg_data = '0;
  logic        push = 1'b0;
  logic [1:0]  action = ACT_DATA;
  logic [7:0]  data_byte = '0;
  logic [7:0]  palette_index = '0;
  logic [7:0]  palette_red = '0;
  logic [7:0]  palette_green = '0;
  logic [7:0]  palette_blue = '0;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic        kind;
  logic [11:0] out_row;
  logic [11:0] start_column;
  logic [7:0]  run_length;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;

  req_t    pending[$];
  result_t runs_due[$];

  logic [12:0]  dec_width;
  logic [12:0]  dec_height;
  logic         dec_bottom;
  parse_phase_t dec_phase;
  logic [7:0]   dec_held;
  logic [7:0]   dec_left;
  logic [7:0]   dec_dx;
  int           dec_col;
  int           dec_row;
  logic         dec_done;
  logic [23:0]  palette_copy[PALETTE_ENTRIES];

  int items_taken = 0;
  int seen_taken = 0;
  int quiet_edges = 0;
  int cfg_writes = 0;
  int results_seen = 0;
  int ends_seen = 0;
  int mismatches = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  stall_mode_t stall_mode = POP_ALWAYS;
  int mode_left = 0;
  int beat = 0;

  bmp_rle8_decoder DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp_dim(input logic [12:0] v, input int limit);
    if (v == 13'd0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  task automatic restart_decoder();
    dec_phase = PH_FIRST;
    dec_held = '0;
    dec_left = '0;
    dec_dx = '0;
    dec_col = 0;
    dec_row = 0;
    dec_done = 1'b0;
  endtask

  task automatic post_run(input int col, input int len, input logic [7:0] idx);
    result_t r;
    int h;
    int row;
    h = clamp_dim(dec_height, DEF_MAX_HEIGHT);
    row = dec_row;
    if (row >= h) row = h - 1;
    if (dec_bottom) row = h - 1 - row;
    r.kind = KIND_RUN;
    r.row = row[11:0];
    r.column = (col > 4095) ? 12'd4095 : col[11:0];
    r.length = len[7:0];
    {r.red, r.green, r.blue} = palette_copy[idx];
    runs_due.push_back(r);
  endtask

  task automatic post_end();
    result_t r;
    r = '0;
    r.kind = KIND_END;
    dec_done = 1'b1;
    runs_due.push_back(r);
  endtask

  task automatic advance_decoder(input logic [1:0] act, input logic [7:0] b,
                                 input logic [7:0] idx, input logic [23:0] rgb);
    int w;
    int h;
    int len;
    int t;
    if (act == ACT_PALETTE) begin
      palette_copy[idx] = rgb;
    end else if (act == ACT_RESTART) begin
      restart_decoder();
    end else if (act == ACT_DATA && !dec_done) begin
      w = clamp_dim(dec_width, DEF_MAX_WIDTH);
      h = clamp_dim(dec_height, DEF_MAX_HEIGHT);
      case (dec_phase)
        PH_COLOUR: begin
          len = 0;
          if (dec_col < w) begin
            len = (int'(dec_held) < w - dec_col) ? int'(dec_held) : w - dec_col;
          end
          t = dec_col;
          dec_col += len;
          dec_phase = PH_FIRST;
          post_run(t, len, b);
        end
        PH_ESCAPE: begin
          dec_phase = PH_FIRST;
          if (b == ESC_EOL) begin
            dec_row++;
            dec_col = 0;
            if (dec_row >= h) post_end();
          end else if (b == ESC_EOB) begin
            post_end();
          end else if (b == ESC_DELTA) begin
            dec_phase = PH_DX;
          end else begin
            dec_held = b;
            dec_left = b;
            dec_phase = PH_ABS;
          end
        end
        PH_DX: begin
          dec_dx = b;
          dec_phase = PH_DY;
        end
        PH_DY: begin
          t = dec_col + int'(dec_dx);
          dec_col = (t > COL_LIMIT) ? COL_LIMIT : t;
          t = dec_row + int'(b);
          dec_row = (t > COL_LIMIT) ? COL_LIMIT : t;
          dec_phase = PH_FIRST;
          if (dec_row >= h) post_end();
        end
        PH_ABS: begin
          if (dec_col < w) begin
            post_run(dec_col, 1, b);
            dec_col++;
          end
          if (dec_left > 0) dec_left--;
          if (dec_left == 0) dec_phase = dec_held[0] ? PH_PAD : PH_FIRST;
        end
        PH_PAD: begin
          dec_phase = PH_FIRST;
        end
        default: begin
          if (b == ESC_MARK) begin
            dec_phase = PH_ESCAPE;
          end else begin
            dec_held = b;
            dec_phase = PH_COLOUR;
          end
        end
      endcase
    end
  endtask

  task automatic queue_req(input logic [1:0] act, input logic [7:0] b,
                           input logic [7:0] idx, input logic [23:0] rgb);
    req_t r;
    r.is_cfg = 1'b0;
    r.reg_idx = REG_WIDTH;
    r.reg_val = '0;
    r.act = act;
    r.byte_val = b;
    r.pal_idx = idx;
    r.rgb = rgb;
    pending.push_back(r);
  endtask

  task automatic queue_byte(input logic [7:0] b);
    queue_req(ACT_DATA, b, 8'($urandom), 24'($urandom));
  endtask

  task automatic queue_palette(input logic [7:0] idx, input logic [23:0] rgb);
    queue_req(ACT_PALETTE, 8'($urandom), idx, rgb);
  endtask

  task automatic queue_action(input logic [1:0] act);
    queue_req(act, 8'($urandom), 8'($urandom), 24'($urandom));
  endtask

  task automatic queue_config(input logic [1:0] idx, input int value);
    req_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = value[12:0];
    pending.push_back(r);
  endtask

  task automatic queue_delta(input logic [7:0] dx, input logic [7:0] dy);
    queue_byte(ESC_MARK);
    queue_byte(ESC_DELTA);
    queue_byte(dx);
    queue_byte(dy);
  endtask

  task automatic queue_random_sequence();
    int pick;
    int n;
    int i;
    pick = $urandom_range(0, 99);
    if (pick < 36) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 16);
      queue_byte(8'(n));
      queue_byte(8'($urandom));
    end else if (pick < 52) begin
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 12);
      queue_byte(ESC_MARK);
      queue_byte(8'(n));
      for (i = 0; i < n; i++) queue_byte(8'($urandom));
      if (n % 2 == 1) queue_byte(8'($urandom));
    end else if (pick < 66) begin
      queue_byte(ESC_MARK);
      queue_byte(ESC_EOL);
    end else if (pick < 77) begin
      n = $urandom_range(0, 9);
      queue_delta(8'($urandom), (n < 6) ? 8'd0 : (n < 9) ? 8'($urandom_range(1, 3))
                                                         : 8'($urandom));
    end else if (pick < 80) begin
      queue_byte(ESC_MARK);
      queue_byte(ESC_EOB);
    end else if (pick < 87) begin
      queue_palette(8'($urandom), 24'($urandom));
    end else if (pick < 92) begin
      queue_action(ACT_RESTART);
    end else if (pick < 95) begin
      queue_action(ACT_UNUSED);
    end else begin
      queue_byte(8'($urandom));
    end
  endtask

  always @(posedge clk) begin : intake
    req_t dropped;
    if (rst) begin
      dec_width = 13'd1;
      dec_height = 13'd1;
      dec_bottom = 1'b1;
      restart_decoder();
      quiet_edges = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_WIDTH:  dec_width = cfg_data;
          REG_HEIGHT: dec_height = cfg_data;
          REG_BOTTOM: dec_bottom = cfg_data[0];
          default: ;
        endcase
        cfg_writes++;
        dropped = pending.pop_front();
      end
      if (push && !full) begin
        advance_decoder(action, data_byte, palette_index,
                        {palette_red, palette_green, palette_blue});
        dropped = pending.pop_front();
        items_taken++;
        quiet_edges = 0;
      end else begin
        quiet_edges++;
      end
    end
  end

  always @(negedge clk) begin : sender
    req_t head;
    logic go_push;
    logic go_cfg;
    go_push = 1'b0;
    go_cfg = 1'b0;
    head = '0;
    if (!rst) begin
      if (items_taken != seen_taken) begin
        seen_taken = items_taken;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(100, 300);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = $urandom_range(1, 8);
          end
        end
      end
      if (pending.size() > 0) begin
        head = pending[0];
        if (head.is_cfg) begin
          go_cfg = (runs_due.size() == 0) && (quiet_edges >= SETTLE_CYCLES);
        end else if (gap_left > 0) begin
          gap_left--;
        end else begin
          go_push = 1'b1;
        end
      end
    end
    push <= go_push;
    cfg_write <= go_cfg;
    if (go_push) begin
      action <= head.act;
      data_byte <= head.byte_val;
      palette_index <= head.pal_idx;
      palette_red <= head.rgb[23:16];
      palette_green <= head.rgb[15:8];
      palette_blue <= head.rgb[7:0];
    end
    if (go_cfg) begin
      cfg_index <= head.reg_idx;
      cfg_data <= head.reg_val;
    end
  end

  always @(negedge clk) begin : receiver
    logic take;
    take = 1'b0;
    if (!rst) begin
      if (!hold_done && items_taken >= HOLD_AT) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 300);
      end else begin
        mode_left--;
      end
      beat++;
      if (hold_left > 0) begin
        hold_left--;
      end else begin
        case (stall_mode)
          POP_ALWAYS:   take = 1'b1;
          POP_COIN:     take = ($urandom_range(0, 1) == 1);
          POP_PERIODIC: take = (beat % 4 != 0);
          default:      take = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
    pop <= take;
  end

  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (!rst && pop && !empty) begin
      got.kind = kind;
      got.row = out_row;
      got.column = start_column;
      got.length = run_length;
      got.red = red;
      got.green = green;
      got.blue = blue;
      results_seen++;
      if (got.kind == KIND_END) ends_seen++;
      if (runs_due.size() == 0) begin
        if (mismatches < 10) begin
          $display("%0t: result with nothing expected: kind=%0d row=%0d col=%0d len=%0d rgb=%06h",
                   $realtime, got.kind, got.row, got.column, got.length,
                   {got.red, got.green, got.blue});
        end
        mismatches++;
      end else begin
        want = runs_due.pop_front();
        if (got !== want) begin
          if (mismatches < 10) begin
            $display("%0t: expected kind=%0d row=%0d col=%0d len=%0d rgb=%06h", $realtime,
                     want.kind, want.row, want.column, want.length,
                     {want.red, want.green, want.blue});
            $display("%0t: actual   kind=%0d row=%0d col=%0d len=%0d rgb=%06h", $realtime,
                     got.kind, got.row, got.column, got.length,
                     {got.red, got.green, got.blue});
          end
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int idle_edges;
    idle_edges = 0;
    while (idle_edges < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty) || cfg_write) idle_edges = 0;
      else idle_edges++;
    end
    $display("Timeout: no request or result moved for %0d cycles", STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int p;
    int w;
    int h;
    int bu;
    int i;
    int base;
    int leftover;

    // Directed part, starting under the register values left by reset.
    queue_palette(8'h00, 24'h000000);
    queue_palette(8'hFF, 24'hFFFFFF);
    queue_palette(8'hA5, 24'hC35A96);
    queue_byte(8'd2);
    queue_byte(8'hA5);
    queue_byte(ESC_MARK);
    queue_byte(ESC_EOB);
    queue_action(ACT_RESTART);
    queue_config(REG_WIDTH, 8);
    queue_config(REG_HEIGHT, 4);
    queue_config(REG_BOTTOM, 0);
    queue_config(REG_NONE, 8191);
    queue_byte(8'd3);
    queue_byte(8'hA5);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_byte(8'd1);
    queue_byte(8'hFF);
    queue_byte(ESC_MARK);
    queue_byte(ESC_EOL);
    queue_byte(ESC_MARK);
    queue_byte(8'd3);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_byte(8'hA5);
    queue_byte(8'h7E);
    queue_delta(8'd5, 8'd1);
    queue_byte(ESC_MARK);
    queue_byte(8'd4);
    for (i = 0; i < 4; i++) queue_byte(8'hA5);
    queue_action(ACT_UNUSED);
    queue_byte(ESC_MARK);
    queue_byte(ESC_EOB);
    queue_byte(8'd5);
    queue_action(ACT_RESTART);

    // Fill the whole palette so that any random index byte is safe.
    for (i = 0; i < PALETTE_ENTRIES; i++) queue_palette(8'(i), 24'($urandom));

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin w = 1; h = 1; bu = 1; end
        1: begin w = 0; h = 0; bu = 0; end
        2: begin w = 8191; h = 8191; bu = 1; end
        3: begin w = 4096; h = 4096; bu = 0; end
        4: begin w = 4097; h = 3; bu = 1; end
        default: begin
          w = $urandom_range(1, 64);
          h = $urandom_range(1, 12);
          bu = $urandom_range(0, 1);
        end
      endcase
      queue_config(REG_WIDTH, w);
      queue_config(REG_HEIGHT, h);
      queue_config(REG_BOTTOM, bu);
      queue_action(ACT_RESTART);
      if (w == 4096) begin
        // Walk the column past 4095 and into saturation, then place a run there.
        queue_byte(8'd9);
        queue_byte(8'($urandom));
        for (i = 0; i < 33; i++) queue_delta(8'hFF, 8'h00);
        queue_byte(8'd1);
        queue_byte(8'($urandom));
      end
      base = pending.size();
      while (pending.size() - base < PHASE_ITEMS) queue_random_sequence();
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || runs_due.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);

    leftover = runs_due.size();
    if (leftover != 0) $display("%0d expected results never arrived", leftover);
    $display("Covered %0d requests and %0d register writes over %0d register settings.",
             items_taken, cfg_writes, PHASES + 2);
    $display("Checked %0d results (%0d end of image), receiver held off once for %0d cycles.",
             results_seen, ends_seen, LONG_HOLD);
    if (mismatches == 0 && leftover == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
